FILE: rtl/core/wrm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrm_pkg
// Shared widths, register indexes, reset values and the transfer type that
// carries a finished window sum from the front end to the back end.
// ----------------------------------------------------------------------------
package wrm_pkg;

   localparam int DATA_W  = 16;   // sample, offset, gain
   localparam int RMS_W   = 17;
   localparam int SUM_W   = 48;
   localparam int DIFF_W  = 17;   // signed sample - offset
   localparam int PROD_W  = 34;   // signed diff * gain
   localparam int SHIFT   = 15;
   localparam int LINE_W  = 19;   // signed Q.4 line voltage
   localparam int MAG_W   = 17;
   localparam int SQ_W    = 2 * MAG_W;
   localparam int CSR_IDX_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN   = 8'd1;

   localparam logic [DATA_W-1:0] OFFSET_RESET = 16'd16568;
   localparam logic [DATA_W-1:0] GAIN_RESET   = 16'd27114;

   typedef struct packed {
      logic             valid;
      logic [SUM_W-1:0] sum;
   } sum_xfer_type;

endpackage : wrm_pkg
`default_nettype wire

FILE: rtl/core/wrm_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrm_front
// Sample pipeline: offset and gain, floor shift and square, then window
// accumulation. A finished window sum is pushed to the queue.
// ----------------------------------------------------------------------------
module wrm_front #(
   parameter int WINDOW = 20
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire  [wrm_pkg::DATA_W-1:0]   req_sample,
   input  wire  [wrm_pkg::DATA_W-1:0]   offset,
   input  wire  [wrm_pkg::DATA_W-1:0]   gain,
   input  wire                          queue_full,
   output wrm_pkg::sum_xfer_type        push
);
   import wrm_pkg::*;

   localparam int CNT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW - 1);

   logic                     advance;
   logic                     win_end;
   logic signed [DIFF_W-1:0] diff;
   logic signed [DIFF_W-1:0] gain_s;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic                     s1_valid_ff;
   logic signed [PROD_W-1:0] line_full;
   logic signed [LINE_W-1:0] line_v;
   logic [LINE_W-1:0]        mag_wide;
   logic [MAG_W-1:0]         mag;
   logic [SQ_W-1:0]          sq_in;
   logic [SQ_W-1:0]          sq_ff;
   logic                     s2_valid_ff;
   logic [SUM_W-1:0]         sum_next;
   logic [SUM_W-1:0]         sum_in;
   logic [SUM_W-1:0]         sum_ff;
   logic [CNT_W-1:0]         count_in;
   logic [CNT_W-1:0]         count_ff;

   assign win_end   = (count_ff == CNT_LAST);
   // hold the whole pipe while a window end waits for queue room
   assign advance   = !(s2_valid_ff && win_end && queue_full);
   assign req_stall = !advance;

   assign diff    = $signed({1'b0, req_sample}) - $signed({1'b0, offset});
   assign gain_s  = $signed({1'b0, gain});
   assign prod_in = diff * gain_s;

   // arithmetic shift floors toward minus infinity
   assign line_full = prod_ff >>> SHIFT;
   assign line_v    = line_full[LINE_W-1:0];
   assign mag_wide  = line_v[LINE_W-1] ? LINE_W'(-line_v) : LINE_W'(line_v);
   assign mag       = mag_wide[MAG_W-1:0];
   assign sq_in     = mag * mag;

   assign sum_next = sum_ff + SUM_W'(sq_ff);

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (s2_valid_ff) begin
         if (win_end) begin
            sum_in   = '0;
            count_in = '0;
         end else begin
            sum_in   = sum_next;
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   assign push.valid = s2_valid_ff && win_end && advance;
   assign push.sum   = sum_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         sum_ff      <= '0;
         count_ff    <= '0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         sum_ff      <= sum_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         sq_ff   <= sq_in;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_LAST)
      else $error("window count past last sample");

   a_clear_after_push: assert property (@(posedge clock) disable iff (reset)
      push.valid |=> (sum_ff == '0) && (count_ff == '0))
      else $error("accumulator not cleared after window transfer");

   a_hold_on_full: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && win_end && queue_full) |=> $stable(sum_ff) && s2_valid_ff)
      else $error("window end lost while queue full");

endmodule : wrm_front
`default_nettype wire

FILE: rtl/core/wrm_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrm_queue
// Two-entry queue of window sums between the front end and the back end.
// ----------------------------------------------------------------------------
module wrm_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wrm_pkg::sum_xfer_type  push,
   output logic                   full,
   input  wire                    pop,
   output wrm_pkg::sum_xfer_type  head
);
   import wrm_pkg::*;

   logic [SUM_W-1:0] entry_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;

   assign full       = (count_ff == 2'd2);
   assign head.valid = (count_ff != 2'd0);
   assign head.sum   = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push.valid && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push.valid && pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push.valid) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.sum;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !full)
      else $error("transfer into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("pop from empty queue");

endmodule : wrm_queue
`default_nettype wire

FILE: rtl/core/wrm_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrm_back
// Window result unit: divides the sum by WINDOW eight quotient bits a cycle,
// then takes the floor square root one result bit a cycle, into an output
// register.
// ----------------------------------------------------------------------------
module wrm_back #(
   parameter int WINDOW = 20
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wrm_pkg::sum_xfer_type        head,
   output logic                         pop,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [wrm_pkg::RMS_W-1:0]    rsp_rms
);
   import wrm_pkg::*;

   localparam int REM_W      = $clog2(WINDOW) + 1;
   localparam int DIV_BITS   = 8;
   localparam int DIV_CYCLES = SUM_W / DIV_BITS;
   localparam int SQRT_STEPS = SUM_W / 2;
   localparam int STEP_W     = $clog2(SQRT_STEPS);
   localparam logic [REM_W-1:0] DIVISOR   = REM_W'(WINDOW);
   localparam logic [SUM_W-1:0] SQRT_BIT0 = {2'b01, {(SUM_W - 2){1'b0}}};

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_SQRT = 4'b0100,
      ST_DONE = 4'b1000
   } back_state_type;

   back_state_type   state_ff, state_in;
   logic [SUM_W-1:0] work_ff, work_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [SUM_W-1:0] root_ff, root_in;
   logic [SUM_W-1:0] bit_ff, bit_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RMS_W-1:0] rsp_rms_ff, rsp_rms_in;
   logic             out_free;

   logic [SUM_W-1:0] div_work;
   logic [REM_W-1:0] div_rem;
   logic [REM_W-1:0] div_t;
   logic [SUM_W-1:0] trial;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pop       = (state_ff == ST_IDLE) && head.valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_rms   = rsp_rms_ff;

   // restoring division: quotient bits shift in behind the dividend
   always_comb begin
      div_work = work_ff;
      div_rem  = rem_ff;
      div_t    = '0;
      for (int i = 0; i < DIV_BITS; i++) begin
         div_t = (div_rem << 1) | REM_W'(div_work[SUM_W-1]);
         if (div_t >= DIVISOR) begin
            div_rem  = div_t - DIVISOR;
            div_work = {div_work[SUM_W-2:0], 1'b1};
         end else begin
            div_rem  = div_t;
            div_work = {div_work[SUM_W-2:0], 1'b0};
         end
      end
   end

   assign trial = root_ff + bit_ff;

   always_comb begin
      state_in     = state_ff;
      work_in      = work_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;
      step_in      = step_ff;
      rsp_rms_in   = rsp_rms_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               work_in  = head.sum;
               rem_in   = '0;
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            work_in = div_work;
            rem_in  = div_rem;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_CYCLES - 1)) begin
               root_in  = '0;
               bit_in   = SQRT_BIT0;
               step_in  = '0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (work_ff >= trial) begin
               work_in = work_ff - trial;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in  = bit_ff >> 2;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(SQRT_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_rms_in   = root_ff[RMS_W-1:0];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff    <= work_in;
      rem_ff     <= rem_in;
      root_ff    <= root_in;
      bit_ff     <= bit_in;
      step_ff    <= step_in;
      rsp_rms_ff <= rsp_rms_in;
   end

endmodule : wrm_back
`default_nettype wire

FILE: rtl/core/windowed_rms_meter.sv
// Path: the result of a window follows its last sample transfer through the
// front stages, the queue, the division and 24 root steps.
// Throughput: one sample per cycle unless stalled; the result unit takes one
// window at a time; a window end meeting a full two-entry queue stalls input.
// Reset: synchronous, active high; clears sum, count, queue and result unit,
// and loads offset 16568 and gain 27114.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_rms_meter
// Windowed RMS meter: offset, gain and square per sample, window mean and
// floor square root per window. Holds the configuration registers.
// ----------------------------------------------------------------------------
module windowed_rms_meter #(
   parameter int WINDOW = 20
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_stall,
   input  wire  [wrm_pkg::DATA_W-1:0]     req_sample,
   output logic                           rsp_valid,
   input  wire                            rsp_stall,
   output logic [wrm_pkg::RMS_W-1:0]      rsp_rms,
   input  wire                            csr_valid,
   output logic                           csr_ready,
   input  wire  [wrm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire  [wrm_pkg::DATA_W-1:0]     csr_wdata
);
   import wrm_pkg::*;

   logic [DATA_W-1:0] offset_ff;
   logic [DATA_W-1:0] gain_ff;
   sum_xfer_type      push;
   sum_xfer_type      head;
   logic              queue_full;
   logic              pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OFFSET_RESET;
         gain_ff   <= GAIN_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_OFFSET: offset_ff <= csr_wdata;
            CSR_GAIN:   gain_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   wrm_front #(.WINDOW(WINDOW)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .offset     (offset_ff),
      .gain       (gain_ff),
      .queue_full (queue_full),
      .push       (push)
   );

   wrm_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .pop   (pop),
      .head  (head)
   );

   wrm_back #(.WINDOW(WINDOW)) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_rms   (rsp_rms)
   );

endmodule : windowed_rms_meter
`default_nettype wire
